/* rtl/tcs_pkg.sv */
`timescale 1ns / 1ps
package tcs_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CW = 32;
  localparam int QB = CW + 1;
  localparam int EW = CW + 2;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [CW-1:0]        radius;
    logic                 degenerate;
    logic                 overflow;
  } res_t;

  function automatic int num_w(input int cb);
    return 4 * cb + 9;
  endfunction

  function automatic int den_w(input int cb);
    return 3 * cb + 7;
  endfunction

endpackage

/* rtl/tetrahedron_circumsphere_top.sv */
// Pipeline from input acceptance to the output handshake:
//   8 determinant stages, 34 divider stages, 38 distance and root stages, output buffer.
// Throughput: one item per cycle while the 2-entry output buffer is not full; a full buffer stalls all stages.
// Reset: synchronous active-low rst_n clears all stage valid bits and the buffer count and pointers.
`timescale 1ns / 1ps
module tetrahedron_circumsphere_top #(
  parameter int COORD_BITS = tcs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_p0_x,
  input  logic signed [COORD_BITS-1:0] in_p0_y,
  input  logic signed [COORD_BITS-1:0] in_p0_z,
  input  logic signed [COORD_BITS-1:0] in_p1_x,
  input  logic signed [COORD_BITS-1:0] in_p1_y,
  input  logic signed [COORD_BITS-1:0] in_p1_z,
  input  logic signed [COORD_BITS-1:0] in_p2_x,
  input  logic signed [COORD_BITS-1:0] in_p2_y,
  input  logic signed [COORD_BITS-1:0] in_p2_z,
  input  logic signed [COORD_BITS-1:0] in_p3_x,
  input  logic signed [COORD_BITS-1:0] in_p3_y,
  input  logic signed [COORD_BITS-1:0] in_p3_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [tcs_pkg::CW-1:0] out_center_x,
  output logic signed [tcs_pkg::CW-1:0] out_center_y,
  output logic signed [tcs_pkg::CW-1:0] out_center_z,
  output logic [tcs_pkg::CW-1:0]        out_radius,
  output logic                          out_degenerate,
  output logic                          out_overflow
);
  import tcs_pkg::*;

  localparam int NUMW = num_w(COORD_BITS);
  localparam int DENW = den_w(COORD_BITS);

  logic                         en;
  logic signed [COORD_BITS-1:0] p_in [12];
  logic                         det_v;
  logic [NUMW-1:0]              num_mag [3];
  logic [DENW-1:0]              den_mag;
  logic                         det_neg [3];
  logic                         det_degen;
  logic signed [COORD_BITS-1:0] det_p0 [3];

  logic                         div_v [3];
  logic [QB-1:0]                div_q [3];
  logic                         div_big [3];
  logic [COORD_BITS+1:0]        tag_x;
  logic [COORD_BITS:0]          tag_y;
  logic [COORD_BITS:0]          tag_z;
  logic                         rt_neg [3];
  logic signed [COORD_BITS-1:0] rt_p0 [3];
  logic                         rt_degen;

  logic                         rt_v;
  res_t                         rt_res;

  res_t                         buf_r [2];
  logic                         wptr_r;
  logic                         rptr_r;
  logic [1:0]                   cnt_r;
  logic [1:0]                   cnt_nxt;
  logic                         push;
  logic                         pop;
  res_t                         head;

  assign p_in = '{in_p0_x, in_p0_y, in_p0_z, in_p1_x, in_p1_y, in_p1_z,
                  in_p2_x, in_p2_y, in_p2_z, in_p3_x, in_p3_y, in_p3_z};

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  tcs_det #(.CB(COORD_BITS)) u_det (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(in_valid), .p_i(p_in),
    .v_out(det_v), .num_mag(num_mag), .den_mag(den_mag), .neg(det_neg),
    .degen(det_degen), .p0(det_p0)
  );

  tcs_div #(.NW(NUMW), .DW(DENW), .TW(COORD_BITS + 2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(det_v), .a(num_mag[0]), .d(den_mag),
    .tag_in({det_degen, det_neg[0], det_p0[0]}),
    .v_out(div_v[0]), .q(div_q[0]), .big(div_big[0]), .tag_out(tag_x)
  );

  tcs_div #(.NW(NUMW), .DW(DENW), .TW(COORD_BITS + 1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(det_v), .a(num_mag[1]), .d(den_mag),
    .tag_in({det_neg[1], det_p0[1]}),
    .v_out(div_v[1]), .q(div_q[1]), .big(div_big[1]), .tag_out(tag_y)
  );

  tcs_div #(.NW(NUMW), .DW(DENW), .TW(COORD_BITS + 1)) u_div_z (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(det_v), .a(num_mag[2]), .d(den_mag),
    .tag_in({det_neg[2], det_p0[2]}),
    .v_out(div_v[2]), .q(div_q[2]), .big(div_big[2]), .tag_out(tag_z)
  );

  assign rt_degen  = tag_x[COORD_BITS+1];
  assign rt_neg[0] = tag_x[COORD_BITS];
  assign rt_neg[1] = tag_y[COORD_BITS];
  assign rt_neg[2] = tag_z[COORD_BITS];
  assign rt_p0[0]  = tag_x[COORD_BITS-1:0];
  assign rt_p0[1]  = tag_y[COORD_BITS-1:0];
  assign rt_p0[2]  = tag_z[COORD_BITS-1:0];

  tcs_root #(.CB(COORD_BITS)) u_root (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(div_v[0] & div_v[1] & div_v[2]),
    .q(div_q), .big(div_big), .neg(rt_neg), .p0(rt_p0), .degen(rt_degen),
    .v_out(rt_v), .res(rt_res)
  );

  assign push = en && rt_v;
  assign pop  = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wptr_r] <= rt_res;
  end

  assign head           = buf_r[rptr_r];
  assign out_valid      = (cnt_r != 2'd0);
  assign out_center_x   = head.center_x;
  assign out_center_y   = head.center_y;
  assign out_center_z   = head.center_z;
  assign out_radius     = head.radius;
  assign out_degenerate = head.degenerate;
  assign out_overflow   = head.overflow;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!in_ready && !push))
    else $error("pipeline advanced while output buffer full");

  a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (!out_overflow && out_radius == '0 &&
      out_center_x == '0 && out_center_y == '0 && out_center_z == '0))
    else $error("degenerate result carries nonzero fields");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("output buffer count lost track of a pop");
`endif

endmodule

/* rtl/tcs_det.sv */
`timescale 1ns / 1ps
module tcs_det #(
  parameter int CB = tcs_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 v_in,
  input  logic signed [CB-1:0]                 p_i [12],
  output logic                                 v_out,
  output logic [tcs_pkg::num_w(CB)-1:0]        num_mag [3],
  output logic [tcs_pkg::den_w(CB)-1:0]        den_mag,
  output logic                                 neg [3],
  output logic                                 degen,
  output logic signed [CB-1:0]                 p0 [3]
);
  import tcs_pkg::*;

  localparam int DW   = CB + 1;
  localparam int PW   = 2 * CB + 2;
  localparam int MW   = 2 * CB + 3;
  localparam int SW   = 2 * CB + 3;
  localparam int TDW  = 3 * CB + 4;
  localparam int DETW = 3 * CB + 6;
  localparam int TNW  = 4 * CB + 6;
  localparam int NVW  = 4 * CB + 8;
  localparam int DENW = den_w(CB);
  localparam int PRW  = 4 * CB + 7;
  localparam int NUMW = num_w(CB);
  localparam int NS   = 8;

  logic [NS-1:0]          v_r;
  logic signed [CB-1:0]   p0_r [NS][3];

  logic signed [DW-1:0]   dv_r [3][3];
  logic signed [PW-1:0]   sq_r [3][3];
  logic signed [PW-1:0]   pa_r [3][3];
  logic signed [PW-1:0]   pb_r [3][3];
  logic signed [DW-1:0]   dv0_2_r [3];
  logic signed [DW-1:0]   dv0_3_r [3];
  logic signed [MW-1:0]   mn_r [3][3];
  logic signed [SW-1:0]   s_r [3];
  logic signed [TDW-1:0]  tdet_r [3];
  logic signed [TNW-1:0]  tnv_r [3][3];
  logic signed [DETW-1:0] det_r;
  logic signed [NVW-1:0]  nv5_r [3];
  logic signed [NVW-1:0]  nv6_r [3];
  logic signed [DENW-1:0] den6_r;
  logic signed [PRW-1:0]  prod_r [3];
  logic                   degen_r [5:7];
  logic signed [NUMW-1:0] num_r [3];
  logic signed [DENW-1:0] den7_r;
  logic [NUMW-1:0]        mag_r [3];
  logic [DENW-1:0]        dmag_r;
  logic                   neg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[0][k] <= p_i[k];
        for (int n = 1; n < NS; n++) p0_r[n][k] <= p0_r[n-1][k];
      end
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          dv_r[i][k] <= DW'(p_i[(i+1)*3+k]) - DW'(p_i[k]);

      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++)
          sq_r[i][k] <= PW'(dv_r[i][k]) * PW'(dv_r[i][k]);
        for (int t = 0; t < 3; t++) begin
          pa_r[t][i] <= PW'(dv_r[(i == 2) ? 0 : i + 1][(t == 2) ? 0 : t + 1])
                      * PW'(dv_r[(i == 0) ? 2 : i - 1][(t == 0) ? 2 : t - 1]);
          pb_r[t][i] <= PW'(dv_r[(i == 0) ? 2 : i - 1][(t == 2) ? 0 : t + 1])
                      * PW'(dv_r[(i == 2) ? 0 : i + 1][(t == 0) ? 2 : t - 1]);
        end
        dv0_2_r[i] <= dv_r[i][0];
      end

      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++) mn_r[t][i] <= MW'(pa_r[t][i]) - MW'(pb_r[t][i]);
        s_r[i] <= SW'(sq_r[i][0]) + SW'(sq_r[i][1]) + SW'(sq_r[i][2]);
        dv0_3_r[i] <= dv0_2_r[i];
      end

      for (int i = 0; i < 3; i++) begin
        tdet_r[i] <= TDW'(mn_r[0][i]) * TDW'(dv0_3_r[i]);
        for (int t = 0; t < 3; t++) tnv_r[t][i] <= TNW'(mn_r[t][i]) * TNW'(s_r[i]);
      end

      det_r <= DETW'(tdet_r[0]) + DETW'(tdet_r[1]) + DETW'(tdet_r[2]);
      for (int t = 0; t < 3; t++)
        nv5_r[t] <= NVW'(tnv_r[t][0]) + NVW'(tnv_r[t][1]) + NVW'(tnv_r[t][2]);

      den6_r <= DENW'(det_r) <<< 1;
      degen_r[5] <= (det_r == '0);
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= (PRW'(det_r) * PRW'(p0_r[4][k])) <<< 1;
        nv6_r[k]  <= nv5_r[k];
      end

      for (int k = 0; k < 3; k++) num_r[k] <= NUMW'(prod_r[k]) + NUMW'(nv6_r[k]);
      den7_r     <= den6_r;
      degen_r[6] <= degen_r[5];

      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= num_r[k][NUMW-1] ^ den7_r[DENW-1];
        mag_r[k] <= num_r[k][NUMW-1] ? NUMW'(-num_r[k]) : NUMW'(num_r[k]);
      end
      dmag_r     <= den7_r[DENW-1] ? DENW'(-den7_r) : DENW'(den7_r);
      degen_r[7] <= degen_r[6];
    end
  end

  assign v_out   = v_r[NS-1];
  assign num_mag = mag_r;
  assign den_mag = dmag_r;
  assign neg     = neg_r;
  assign degen   = degen_r[7];
  assign p0      = p0_r[NS-1];

endmodule

/* rtl/tcs_div.sv */
`timescale 1ns / 1ps
module tcs_div #(
  parameter int NW = tcs_pkg::num_w(tcs_pkg::COORD_BITS_DEF),
  parameter int DW = tcs_pkg::den_w(tcs_pkg::COORD_BITS_DEF),
  parameter int TW = tcs_pkg::COORD_BITS_DEF + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [NW-1:0]          a,
  input  logic [DW-1:0]          d,
  input  logic [TW-1:0]          tag_in,
  output logic                   v_out,
  output logic [tcs_pkg::QB-1:0] q,
  output logic                   big,
  output logic [TW-1:0]          tag_out
);
  import tcs_pkg::*;

  localparam int RW = (NW > DW + QB) ? NW : DW + QB;

  logic [QB:0]    v_r;
  logic [RW-1:0]  r_r   [QB+1];
  logic [DW-1:0]  ds_r  [QB+1];
  logic [QB-1:0]  q_r   [QB+1];
  logic           big_r [QB+1];
  logic [TW-1:0]  tag_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QB-1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RW'(a);
      ds_r[0]  <= d;
      q_r[0]   <= '0;
      big_r[0] <= RW'(a) >= (RW'(d) << QB);
      tag_r[0] <= tag_in;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_st
    localparam int B = QB - s;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(ds_r[s-1]) << B;
    assign ge = r_r[s-1] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s]   <= ge ? r_r[s-1] - sh : r_r[s-1];
        q_r[s]   <= ge ? (q_r[s-1] | (QB'(1) << B)) : q_r[s-1];
        ds_r[s]  <= ds_r[s-1];
        big_r[s] <= big_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign v_out   = v_r[QB];
  assign q       = q_r[QB];
  assign big     = big_r[QB];
  assign tag_out = tag_r[QB];

endmodule

/* rtl/tcs_root.sv */
`timescale 1ns / 1ps
module tcs_root #(
  parameter int CB = tcs_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [tcs_pkg::QB-1:0] q [3],
  input  logic                   big [3],
  input  logic                   neg [3],
  input  logic signed [CB-1:0]   p0 [3],
  input  logic                   degen,
  output logic                   v_out,
  output tcs_pkg::res_t          res
);
  import tcs_pkg::*;

  localparam int DISTW = 2 * EW;
  localparam int RB    = DISTW / 2;
  localparam int REMW  = RB + 3;
  localparam int NS    = RB + 4;
  localparam int LAST  = RB + 2;

  localparam logic [QB-1:0] LIM_N = QB'(1) << (CW - 1);
  localparam logic [QB-1:0] LIM_P = LIM_N - QB'(1);
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  logic [NS-1:0]          v_r;
  logic signed [CW-1:0]   c_r    [LAST+1][3];
  logic                   ovf_r  [LAST+1];
  logic                   dg_r   [LAST+1];
  logic signed [CB-1:0]   p0_r   [3];
  logic [DISTW-1:0]       sq_r   [3];
  logic [DISTW-1:0]       dist_r [LAST+1];
  logic [REMW-1:0]        rem_r  [LAST+1];
  logic [RB-1:0]          root_r [LAST+1];
  res_t                   res_r;

  logic signed [CW-1:0]   c_nxt [3];
  logic                   ovf_nxt;
  logic signed [EW-1:0]   e [3];

  always_comb begin
    ovf_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (neg[k]) begin
        if (big[k] || q[k] > LIM_N) begin
          c_nxt[k] = CMIN;
          ovf_nxt  = 1'b1;
        end else begin
          c_nxt[k] = -CW'(q[k]);
        end
      end else begin
        if (big[k] || q[k] > LIM_P) begin
          c_nxt[k] = CMAX;
          ovf_nxt  = 1'b1;
        end else begin
          c_nxt[k] = CW'(q[k]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) e[k] = EW'(c_r[0][k]) - EW'(p0_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= c_nxt;
      ovf_r[0] <= ovf_nxt;
      dg_r[0]  <= degen;
      p0_r     <= p0;

      for (int k = 0; k < 3; k++) sq_r[k] <= DISTW'(DISTW'(e[k]) * DISTW'(e[k]));
      c_r[1]   <= c_r[0];
      ovf_r[1] <= ovf_r[0];
      dg_r[1]  <= dg_r[0];

      dist_r[2] <= sq_r[0] + sq_r[1] + sq_r[2];
      rem_r[2]  <= '0;
      root_r[2] <= '0;
      c_r[2]    <= c_r[1];
      ovf_r[2]  <= ovf_r[1];
      dg_r[2]   <= dg_r[1];
    end
  end

  for (genvar n = 3; n <= LAST; n++) begin : g_sq
    logic [REMW-1:0] remx;
    logic [REMW-1:0] trial;
    logic            ge;
    assign remx  = {rem_r[n-1][REMW-3:0], dist_r[n-1][DISTW-1 -: 2]};
    assign trial = REMW'({root_r[n-1], 2'b01});
    assign ge    = remx >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[n]  <= ge ? remx - trial : remx;
        root_r[n] <= {root_r[n-1][RB-2:0], ge};
        dist_r[n] <= dist_r[n-1] << 2;
        c_r[n]    <= c_r[n-1];
        ovf_r[n]  <= ovf_r[n-1];
        dg_r[n]   <= dg_r[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dg_r[LAST]) begin
        res_r <= '{center_x: '0, center_y: '0, center_z: '0, radius: '0,
                   degenerate: 1'b1, overflow: 1'b0};
      end else begin
        res_r.center_x   <= c_r[LAST][0];
        res_r.center_y   <= c_r[LAST][1];
        res_r.center_z   <= c_r[LAST][2];
        res_r.radius     <= (root_r[LAST][RB-1:CW] != '0) ? {CW{1'b1}}
                                                          : root_r[LAST][CW-1:0];
        res_r.degenerate <= 1'b0;
        res_r.overflow   <= ovf_r[LAST] || (root_r[LAST][RB-1:CW] != '0);
      end
    end
  end

  assign v_out = v_r[NS-1];
  assign res   = res_r;

endmodule

/* verif/tetrahedron_circumsphere_top_tb.sv */
`timescale 1ns / 1ps
module tetrahedron_circumsphere_top_tb;
  import tcs_pkg::*;

  typedef logic [11:0][15:0] tet_t;

  typedef struct {
    tet_t verts;
    bit   typed;
    res_t res;
  } vec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  tet_t cur_tet;
  logic signed [CW-1:0] out_center_x, out_center_y, out_center_z;
  logic [CW-1:0] out_radius;
  logic out_degenerate, out_overflow;

  res_t sphere_q[$];
  int   fails;
  int   cycles;
  bit   burst;
  vec_t dir_tab[$];

  tetrahedron_circumsphere_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_p0_x(cur_tet[0]), .in_p0_y(cur_tet[1]), .in_p0_z(cur_tet[2]),
    .in_p1_x(cur_tet[3]), .in_p1_y(cur_tet[4]), .in_p1_z(cur_tet[5]),
    .in_p2_x(cur_tet[6]), .in_p2_y(cur_tet[7]), .in_p2_z(cur_tet[8]),
    .in_p3_x(cur_tet[9]), .in_p3_y(cur_tet[10]), .in_p3_z(cur_tet[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_center_z(out_center_z), .out_radius(out_radius),
    .out_degenerate(out_degenerate), .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t circumsphere(input tet_t t);
    longint p[4][3];
    longint dv[3][3];
    longint c[3];
    longint e;
    logic signed [127:0] s[3];
    logic signed [127:0] nv[3];
    logic signed [127:0] mx, my, mz, det, den, num, q, ew;
    logic [127:0] d2, root, cand;
    res_t r;
    bit ovf;
    int j, k;
    r = '0;
    ovf = 1'b0;
    for (int i = 0; i < 4; i++)
      for (int a = 0; a < 3; a++)
        p[i][a] = longint'($signed(t[i*3+a]));
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) dv[i][a] = p[i+1][a] - p[0][a];
      s[i] = dv[i][0]*dv[i][0] + dv[i][1]*dv[i][1] + dv[i][2]*dv[i][2];
    end
    det = 0;
    nv[0] = 0; nv[1] = 0; nv[2] = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      mx = dv[j][1]*dv[k][2] - dv[k][1]*dv[j][2];
      my = dv[j][2]*dv[k][0] - dv[k][2]*dv[j][0];
      mz = dv[j][0]*dv[k][1] - dv[k][0]*dv[j][1];
      det = det + mx * dv[i][0];
      nv[0] = nv[0] + mx * s[i];
      nv[1] = nv[1] + my * s[i];
      nv[2] = nv[2] + mz * s[i];
    end
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    den = det + det;
    for (int a = 0; a < 3; a++) begin
      num = den * p[0][a] + nv[a];
      q = num / den;
      if (q > 128'sd2147483647) begin
        c[a] = 2147483647;
        ovf = 1'b1;
      end else if (q < -128'sd2147483648) begin
        c[a] = -2147483648;
        ovf = 1'b1;
      end else begin
        c[a] = longint'(q);
      end
    end
    r.center_x = c[0][31:0];
    r.center_y = c[1][31:0];
    r.center_z = c[2][31:0];
    d2 = 0;
    for (int a = 0; a < 3; a++) begin
      e = c[a] - p[0][a];
      ew = e;
      d2 = d2 + ew * ew;
    end
    root = 0;
    for (int b = 36; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= d2) root = cand;
    end
    if (root > 128'hFFFF_FFFF) begin
      root = 128'hFFFF_FFFF;
      ovf = 1'b1;
    end
    r.radius = root[31:0];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [15:0] small_coord();
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic tet_t rand_tet();
    tet_t t;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      t[i] = (kind < 3) ? 16'($urandom) : small_coord();
    if (kind == 7 || kind == 8) begin
      for (int a = 0; a < 3; a++)
        t[9+a] = t[3+a] + t[6+a] - t[a] + 16'($signed($urandom_range(0, 4)) - 2);
    end else if (kind == 9) begin
      for (int a = 0; a < 3; a++) t[9+a] = t[3+a];
    end
    return t;
  endfunction

  function automatic vec_t mk(input tet_t t);
    vec_t v;
    v.verts = t;
    v.typed = 1'b0;
    v.res = '0;
    return v;
  endfunction

  function automatic vec_t mk_typed(input tet_t t, input res_t r);
    vec_t v;
    v.verts = t;
    v.typed = 1'b1;
    v.res = r;
    return v;
  endfunction

  task automatic send(input tet_t t, input bit typed, input res_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_tet <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sphere_q = {sphere_q, (typed ? r : circumsphere(t))};
  endtask

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (sphere_q.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        w = sphere_q.pop_front();
        if (out_center_x !== w.center_x) begin
          $error("center_x exp %0d got %0d", w.center_x, out_center_x); fails++;
        end
        if (out_center_y !== w.center_y) begin
          $error("center_y exp %0d got %0d", w.center_y, out_center_y); fails++;
        end
        if (out_center_z !== w.center_z) begin
          $error("center_z exp %0d got %0d", w.center_z, out_center_z); fails++;
        end
        if (out_radius !== w.radius) begin
          $error("radius exp %0d got %0d", w.radius, out_radius); fails++;
        end
        if (out_degenerate !== w.degenerate) begin
          $error("degenerate exp %0b got %0b", w.degenerate, out_degenerate); fails++;
        end
        if (out_overflow !== w.overflow) begin
          $error("overflow exp %0b got %0b", w.overflow, out_overflow); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    tet_t t;
    res_t r;
    fails = 0;
    cycles = 0;
    burst = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    cur_tet = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    r = '0;
    r.degenerate = 1'b1;
    dir_tab = {dir_tab, mk_typed('0, r)};
    dir_tab = {dir_tab, mk_typed({12{16'h7FFF}}, r)};
    dir_tab = {dir_tab, mk_typed({12{16'h8000}}, r)};
    t = '0;
    t[3] = 16'd256; t[7] = 16'd256; t[11] = 16'd256;
    r = '0;
    r.center_x = 32'sd128; r.center_y = 32'sd128; r.center_z = 32'sd128;
    r.radius = 32'd221;
    dir_tab = {dir_tab, mk_typed(t, r)};
    t = {12{16'h8000}};
    t[3] = 16'h7FFF; t[7] = 16'h7FFF; t[11] = 16'h7FFF;
    dir_tab = {dir_tab, mk(t)};
    t = {12{16'h7FFF}};
    t[3] = 16'h8000; t[7] = 16'h8000; t[11] = 16'h8000;
    dir_tab = {dir_tab, mk(t)};
    t = '0;
    t[3] = 16'h7FFF; t[7] = 16'h7FFF; t[9] = 16'd16000; t[10] = 16'd16000; t[11] = 16'd1;
    dir_tab = {dir_tab, mk(t)};
    t = '0;
    t[3] = 16'h8000; t[7] = 16'h8000; t[9] = 16'h8000; t[10] = 16'h8000; t[11] = 16'hFFFF;
    dir_tab = {dir_tab, mk(t)};
    t = '0;
    t[3] = 16'd1; t[7] = 16'd1; t[9] = 16'd1; t[10] = 16'd1; t[11] = 16'd1;
    dir_tab = {dir_tab, mk(t)};
    t = {16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB,
         16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00};
    dir_tab = {dir_tab, mk(t)};
    t = '0;
    t[3] = 16'd100; t[6] = 16'd200; t[9] = 16'd300;
    dir_tab = {dir_tab, mk(t)};
    for (int i = 0; i < 6; i++) dir_tab = {dir_tab, mk(rand_tet())};

    foreach (dir_tab[i]) send(dir_tab[i].verts, dir_tab[i].typed, dir_tab[i].res);

    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 650) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sphere_q.size() != 0) @(posedge clk);
      end
      send(rand_tet(), 1'b0, '0);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    burst = 1'b0;
    while (sphere_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
